@@ rtl/sfd_pkg.sv @@
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared constants and control types of the SLIP frame decoder.
// ----------------------------------------------------------------------------
package sfd_pkg;

    localparam int BYTE_W              = 8;
    localparam int LEN_W               = 7;
    localparam int DEFAULT_FRAME_DEPTH = 64;

    localparam logic [BYTE_W-1:0] SLIP_END  = 8'hC0;
    localparam logic [BYTE_W-1:0] SLIP_ESC  = 8'hDB;
    localparam logic [BYTE_W-1:0] SLIP_TEND = 8'hDC;
    localparam logic [BYTE_W-1:0] SLIP_TESC = 8'hDD;

    typedef enum logic [1:0] {
        STORE_RAW,
        STORE_END,
        STORE_ESC
    } store_sel_t;

    typedef struct packed {
        logic       frame_clear;
        logic       store_en;
        store_sel_t store_sel;
        logic       drain_start;
        logic       rd_issue;
    } sfd_cmd_t;

    typedef struct packed {
        logic is_end;
        logic is_esc;
        logic is_tend;
        logic is_tesc;
        logic fill_zero;
        logic rd_ok;
        logic rd_last;
    } sfd_status_t;

endpackage

@@ rtl/slip_frame_decoder.sv @@
// ----------------------------------------------------------------------------
// slip_frame_decoder
// SLIP receiver: takes raw serial bytes, strips framing and escapes, and
// emits each completed frame byte by byte with length and overflow flag.
// ----------------------------------------------------------------------------
// one received byte accepted per cycle while hunting or inside a frame
// a closing end byte of a non-empty frame stalls input while it drains from
// the store; each byte passes the registered store read into the output
// register; a read waits while one is pending or the output byte is untaken
// synchronous active-low reset clears mode, fill count, overflow flag and
// output valid; the frame store itself is not cleared
module slip_frame_decoder import sfd_pkg::*; #(
    parameter int FRAME_DEPTH = DEFAULT_FRAME_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [BYTE_W-1:0] s_tdata,   // [7:0] rx_byte
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [BYTE_W-1:0] m_tdata,   // [7:0] data_byte
    output logic              m_tlast,
    output logic [LEN_W:0]    m_tuser    // [0] overflowed, [7:1] frame_length
);

    sfd_cmd_t    cmd;
    sfd_status_t status;

    sfd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    sfd_datapath #(
        .FRAME_DEPTH (FRAME_DEPTH)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

@@ rtl/sfd_ram.sv @@
// ----------------------------------------------------------------------------
// sfd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/sfd_ctrl.sv @@
// ----------------------------------------------------------------------------
// sfd_ctrl
// Decoder state machine: hunt, in-frame, escape and frame drain.
// ----------------------------------------------------------------------------
module sfd_ctrl import sfd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  sfd_status_t status,
    output sfd_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_HUNT,
        ST_FRAME,
        ST_ESCAPE,
        ST_DRAIN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign s_tready = (state_reg != ST_DRAIN);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next      = state_reg;
        cmd.frame_clear = 1'b0;
        cmd.store_en    = 1'b0;
        cmd.store_sel   = STORE_RAW;
        cmd.drain_start = 1'b0;
        cmd.rd_issue    = 1'b0;
        unique case (state_reg)
            ST_HUNT: begin
                if (accept && status.is_end) begin
                    state_next      = ST_FRAME;
                    cmd.frame_clear = 1'b1;
                end
            end
            ST_FRAME: begin
                if (accept) begin
                    if (status.is_end) begin
                        // empty frame closes quietly
                        if (status.fill_zero) begin
                            state_next = ST_HUNT;
                        end else begin
                            state_next      = ST_DRAIN;
                            cmd.drain_start = 1'b1;
                        end
                    end else if (status.is_esc) begin
                        state_next = ST_ESCAPE;
                    end else begin
                        cmd.store_en = 1'b1;
                    end
                end
            end
            ST_ESCAPE: begin
                if (accept) begin
                    if (status.is_tend) begin
                        cmd.store_en  = 1'b1;
                        cmd.store_sel = STORE_END;
                        state_next    = ST_FRAME;
                    end else if (status.is_tesc) begin
                        cmd.store_en  = 1'b1;
                        cmd.store_sel = STORE_ESC;
                        state_next    = ST_FRAME;
                    end else begin
                        state_next = ST_HUNT;
                    end
                end
            end
            ST_DRAIN: begin
                if (status.rd_ok) begin
                    cmd.rd_issue = 1'b1;
                    if (status.rd_last) begin
                        state_next = ST_HUNT;
                    end
                end
            end
            default: begin
                state_next = ST_HUNT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_HUNT;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/sfd_datapath.sv @@
// ----------------------------------------------------------------------------
// sfd_datapath
// Byte classification, frame store, fill count and output register.
// ----------------------------------------------------------------------------
module sfd_datapath import sfd_pkg::*; #(
    parameter int FRAME_DEPTH = DEFAULT_FRAME_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [BYTE_W-1:0] s_tdata,
    input  sfd_cmd_t          cmd,
    output sfd_status_t       status,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [BYTE_W-1:0] m_tdata,
    output logic              m_tlast,
    output logic [LEN_W:0]    m_tuser
);

    localparam int AW = $clog2(FRAME_DEPTH);
    localparam logic [LEN_W-1:0] DEPTH_LEN = LEN_W'(FRAME_DEPTH);

    logic [LEN_W-1:0]  fill_reg;
    logic              ovf_reg;
    logic [LEN_W-1:0]  drain_len_reg;
    logic              drain_ovf_reg;
    logic [LEN_W-1:0]  rd_ptr_reg;
    logic              pend_valid_reg;
    logic              pend_last_reg;
    logic [LEN_W-1:0]  pend_len_reg;
    logic              pend_ovf_reg;
    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_data_reg;
    logic              out_last_reg;
    logic              out_ovf_reg;
    logic [LEN_W-1:0]  out_len_reg;

    logic              room;
    logic              wr_en;
    logic [BYTE_W-1:0] wr_data;
    logic [BYTE_W-1:0] rd_data;
    logic [LEN_W-1:0]  rd_ptr_inc;

    assign status.is_end    = (s_tdata == SLIP_END);
    assign status.is_esc    = (s_tdata == SLIP_ESC);
    assign status.is_tend   = (s_tdata == SLIP_TEND);
    assign status.is_tesc   = (s_tdata == SLIP_TESC);
    assign status.fill_zero = (fill_reg == '0);
    // read only when no read is pending and the output register is free by the time data lands
    assign status.rd_ok     = !pend_valid_reg && (!out_valid_reg || m_tready);
    assign rd_ptr_inc       = rd_ptr_reg + LEN_W'(1);
    assign status.rd_last   = (rd_ptr_inc == drain_len_reg);

    assign room  = (fill_reg < DEPTH_LEN);
    assign wr_en = cmd.store_en && room;

    always_comb begin
        case (cmd.store_sel)
            STORE_END: wr_data = SLIP_END;
            STORE_ESC: wr_data = SLIP_ESC;
            default:   wr_data = s_tdata;
        endcase
    end

    sfd_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (FRAME_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (fill_reg[AW-1:0]),
        .wdata (wr_data),
        .re    (cmd.rd_issue),
        .raddr (rd_ptr_reg[AW-1:0]),
        .rdata (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg       <= '0;
            ovf_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            rd_ptr_reg     <= '0;
        end else begin
            if (cmd.frame_clear || cmd.drain_start) begin
                fill_reg <= '0;
                ovf_reg  <= 1'b0;
            end else if (cmd.store_en) begin
                if (room) begin
                    fill_reg <= fill_reg + LEN_W'(1);
                end else begin
                    ovf_reg <= 1'b1;
                end
            end

            if (cmd.drain_start) begin
                rd_ptr_reg <= '0;
            end else if (cmd.rd_issue) begin
                rd_ptr_reg <= rd_ptr_inc;
            end

            pend_valid_reg <= cmd.rd_issue;

            if (pend_valid_reg) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.drain_start) begin
            drain_len_reg <= fill_reg;
            drain_ovf_reg <= ovf_reg;
        end
        if (cmd.rd_issue) begin
            pend_last_reg <= status.rd_last;
            pend_len_reg  <= drain_len_reg;
            pend_ovf_reg  <= drain_ovf_reg;
        end
        if (pend_valid_reg) begin
            out_data_reg <= rd_data;
            out_last_reg <= pend_last_reg;
            out_len_reg  <= pend_len_reg;
            out_ovf_reg  <= pend_ovf_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = {out_len_reg, out_ovf_reg};

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Streams raw serial bytes into the SLIP frame decoder and compares every
// decoded byte, its last flag, overflow flag and frame length against an
// in-bench SLIP decoder or a directed row's expected byte. A short table of
// directed bytes comes first, then random frames with escapes, oversized frames, bad escapes and line noise.
// ----------------------------------------------------------------------------
module tb_top;
    import sfd_pkg::*;

    localparam int DEPTH        = DEFAULT_FRAME_DEPTH;
    localparam int RANDOM_ITEMS = 500;
    localparam int IDLE_PCT     = 22;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_TAIL   = 16;

    typedef enum logic [1:0] {
        HUNT,
        IN_FRAME,
        AFTER_ESC
    } rx_state_t;

    typedef enum logic [1:0] {
        CHK_PREDICT,
        CHK_SILENT,
        CHK_SINGLE
    } row_chk_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
        logic              ovf;
        logic [LEN_W-1:0]  len;
    } frame_byte_t;

    typedef struct {
        logic [BYTE_W-1:0] rx;
        row_chk_t          chk;
        logic [BYTE_W-1:0] single;
    } dir_row_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [BYTE_W-1:0] s_tdata = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [BYTE_W-1:0] m_tdata;
    logic              m_tlast;
    logic [LEN_W:0]    m_tuser;

    // in-bench decoder state
    rx_state_t         rx_state = HUNT;
    int                rx_fill = 0;
    logic              rx_dropped = 1'b0;
    logic [BYTE_W-1:0] rx_store [DEPTH];

    frame_byte_t pending_bytes[$];
    dir_row_t    dir_rows[$];
    frame_byte_t want_res;
    frame_byte_t got_res;
    int          err_count = 0;
    int          rx_count = 0;
    int          cycle_cnt = 0;
    logic        no_idle = 1'b0;

    slip_frame_decoder #(.FRAME_DEPTH(DEPTH)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic void store_byte(input logic [BYTE_W-1:0] b);
        if (rx_fill < DEPTH) begin
            rx_store[rx_fill] = b;
            rx_fill++;
        end else begin
            rx_dropped = 1'b1;
        end
    endfunction

    function automatic void predict_rx(input logic [BYTE_W-1:0] b, ref frame_byte_t outs[$]);
        int k;
        case (rx_state)
            IN_FRAME: begin
                if (b == SLIP_END) begin
                    for (k = 0; k < rx_fill; k++) begin
                        outs.push_back('{data: rx_store[k], last: (k + 1 == rx_fill),
                                         ovf: rx_dropped, len: LEN_W'(rx_fill)});
                    end
                    rx_fill    = 0;
                    rx_dropped = 1'b0;
                    rx_state   = HUNT;
                end else if (b == SLIP_ESC) begin
                    rx_state = AFTER_ESC;
                end else begin
                    store_byte(b);
                end
            end
            AFTER_ESC: begin
                if (b == SLIP_TEND) begin
                    store_byte(SLIP_END);
                    rx_state = IN_FRAME;
                end else if (b == SLIP_TESC) begin
                    store_byte(SLIP_ESC);
                    rx_state = IN_FRAME;
                end else begin
                    // bad escape drops the frame
                    rx_state = HUNT;
                end
            end
            default: begin
                if (b == SLIP_END) begin
                    rx_state   = IN_FRAME;
                    rx_fill    = 0;
                    rx_dropped = 1'b0;
                end
            end
        endcase
    endfunction

    function automatic dir_row_t row(input logic [BYTE_W-1:0] rx, input row_chk_t chk,
                                     input logic [BYTE_W-1:0] single);
        dir_row_t r;
        r.rx     = rx;
        r.chk    = chk;
        r.single = single;
        return r;
    endfunction

    // drive one byte from a falling edge, return at the falling edge after it is accepted
    task automatic push_rx(input logic [BYTE_W-1:0] b, input row_chk_t chk,
                           input logic [BYTE_W-1:0] single);
        frame_byte_t fresh[$];
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        // bytes ignored while hunting do not count toward the total
        if (rx_state != HUNT || b == SLIP_END)
            rx_count++;
        predict_rx(b, fresh);
        case (chk)
            CHK_PREDICT: foreach (fresh[i]) pending_bytes.push_back(fresh[i]);
            CHK_SINGLE:  pending_bytes.push_back('{data: single, last: 1'b1, ovf: 1'b0,
                                                   len: LEN_W'(1)});
            default: ;
        endcase
        @(negedge aclk);
    endtask

    task automatic send_frame(input int n_bytes, input logic broken);
        int               i;
        logic [BYTE_W-1:0] v;
        // get back to hunting so the opening end byte really opens
        if (rx_state != HUNT)
            push_rx(SLIP_END, CHK_PREDICT, '0);
        push_rx(SLIP_END, CHK_PREDICT, '0);
        for (i = 0; i < n_bytes; i++) begin
            case ($urandom_range(7))
                0:       v = SLIP_END;
                1:       v = SLIP_ESC;
                default: v = BYTE_W'($urandom_range(255));
            endcase
            if (v == SLIP_END) begin
                push_rx(SLIP_ESC, CHK_PREDICT, '0);
                push_rx(SLIP_TEND, CHK_PREDICT, '0);
            end else if (v == SLIP_ESC) begin
                push_rx(SLIP_ESC, CHK_PREDICT, '0);
                push_rx(SLIP_TESC, CHK_PREDICT, '0);
            end else begin
                push_rx(v, CHK_PREDICT, '0);
            end
        end
        if (broken) begin
            do v = BYTE_W'($urandom_range(255)); while (v == SLIP_TEND || v == SLIP_TESC);
            push_rx(SLIP_ESC, CHK_PREDICT, '0);
            push_rx(v, CHK_PREDICT, '0);
        end else begin
            push_rx(SLIP_END, CHK_PREDICT, '0);
        end
    endtask

    always @(negedge aclk) begin
        m_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("%0t: timeout", $time);
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_res = '{data: m_tdata, last: m_tlast, ovf: m_tuser[0],
                        len: m_tuser[LEN_W:1]};
            if (pending_bytes.size() == 0) begin
                err_count++;
                $display("%0t: unexpected result data %h last %b ovf %b len %0d", $time,
                         got_res.data, got_res.last, got_res.ovf, got_res.len);
            end else begin
                want_res = pending_bytes.pop_front();
                if (got_res.data !== want_res.data || got_res.last !== want_res.last ||
                    got_res.ovf !== want_res.ovf || got_res.len !== want_res.len) begin
                    err_count++;
                    $display("%0t: want %h %b %b %0d, got %h %b %b %0d",
                             $time, want_res.data, want_res.last, want_res.ovf, want_res.len,
                             got_res.data, got_res.last, got_res.ovf, got_res.len);
                end
            end
        end
    end

    initial begin
        int frame_no;
        int pick;
        int n_bytes;

        // noise while hunting, empty frame, extreme bytes, both escapes,
        // a bad escape and a two byte frame
        dir_rows.push_back(row(8'h00, CHK_SILENT, '0));
        dir_rows.push_back(row(8'hFF, CHK_SILENT, '0));
        dir_rows.push_back(row(SLIP_END, CHK_SILENT, '0));
        dir_rows.push_back(row(SLIP_END, CHK_SILENT, '0));
        dir_rows.push_back(row(SLIP_END, CHK_SILENT, '0));
        dir_rows.push_back(row(8'h00, CHK_SILENT, '0));
        dir_rows.push_back(row(SLIP_END, CHK_SINGLE, 8'h00));
        dir_rows.push_back(row(SLIP_END, CHK_SILENT, '0));
        dir_rows.push_back(row(8'hFF, CHK_SILENT, '0));
        dir_rows.push_back(row(SLIP_END, CHK_SINGLE, 8'hFF));
        dir_rows.push_back(row(SLIP_END, CHK_SILENT, '0));
        dir_rows.push_back(row(SLIP_ESC, CHK_SILENT, '0));
        dir_rows.push_back(row(SLIP_TEND, CHK_SILENT, '0));
        dir_rows.push_back(row(SLIP_END, CHK_SINGLE, SLIP_END));
        dir_rows.push_back(row(SLIP_END, CHK_SILENT, '0));
        dir_rows.push_back(row(SLIP_ESC, CHK_SILENT, '0));
        dir_rows.push_back(row(SLIP_TESC, CHK_SILENT, '0));
        dir_rows.push_back(row(SLIP_END, CHK_SINGLE, SLIP_ESC));
        dir_rows.push_back(row(SLIP_END, CHK_SILENT, '0));
        dir_rows.push_back(row(SLIP_ESC, CHK_SILENT, '0));
        dir_rows.push_back(row(8'h41, CHK_SILENT, '0));
        dir_rows.push_back(row(SLIP_END, CHK_SILENT, '0));
        dir_rows.push_back(row(8'h12, CHK_PREDICT, '0));
        dir_rows.push_back(row(8'h34, CHK_PREDICT, '0));
        dir_rows.push_back(row(SLIP_END, CHK_PREDICT, '0));

        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (dir_rows[i])
            push_rx(dir_rows[i].rx, dir_rows[i].chk, dir_rows[i].single);

        frame_no = 0;
        while (rx_count < dir_rows.size() + RANDOM_ITEMS) begin
            no_idle = (rx_count >= 250 && rx_count < 350);
            // first two frames hit a full store exactly and overflow it
            if (frame_no == 0)
                n_bytes = DEPTH;
            else if (frame_no == 1)
                n_bytes = DEPTH + 3;
            else if ($urandom_range(15) == 0)
                n_bytes = $urandom_range(DEPTH - 4, DEPTH + 6);
            else
                n_bytes = $urandom_range(1, 10);
            pick = $urandom_range(99);
            if (frame_no < 2 || pick < 80) begin
                send_frame(n_bytes, 1'b0);
            end else if (pick < 88) begin
                send_frame($urandom_range(0, 4), 1'b1);
            end else if (pick < 94) begin
                send_frame(0, 1'b0);
            end else begin
                repeat ($urandom_range(1, 3))
                    push_rx(BYTE_W'($urandom_range(255)), CHK_PREDICT, '0);
            end
            frame_no++;
        end
        no_idle = 1'b0;
        s_tvalid <= 1'b0;

        while (pending_bytes.size() != 0) @(posedge aclk);
        repeat (DRAIN_TAIL) @(posedge aclk);
        if (err_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

@@ slip_frame_decoder.f @@
rtl/sfd_pkg.sv
rtl/sfd_ram.sv
rtl/sfd_ctrl.sv
rtl/sfd_datapath.sv
rtl/slip_frame_decoder.sv
tb/sv/tb_top.sv
